// ===== hdl/number_property_classifier_assert.svh =====
// ----------------------------------------------------------------------------
// number property classifier assertion macros
// shared property forms for the classifier checks
// ----------------------------------------------------------------------------
`ifndef NUMBER_PROPERTY_CLASSIFIER_ASSERT_SVH
`define NUMBER_PROPERTY_CLASSIFIER_ASSERT_SVH

// same-cycle implication
`define NPC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("classifier check failed");

// next-cycle implication
`define NPC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("classifier sequencing check failed");

`endif

// ===== hdl/npc_pkg.sv =====
// ----------------------------------------------------------------------------
// npc_pkg
// types and constants for the number property classifier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package npc_pkg;

	typedef struct packed {
		logic prime;
		logic perfect;
		logic square;
		logic sphenic;
	} npc_flags_t;

	localparam int unsigned SPHENIC_FACTORS = 3;

endpackage

`default_nettype wire

// ===== hdl/number_property_classifier.sv =====
// ----------------------------------------------------------------------------
// number_property_classifier
// classifies an unsigned word as prime, perfect, square and sphenic
// ----------------------------------------------------------------------------
// One word is taken at a time; in_stall stays high until it is classified.
// Trial divisors d = 2, 3, ... run while d*d <= value (in the second pass,
// the remaining cofactor), each through one shared bit-serial restoring
// divider, with one shared squarer for the loop bound. A first pass over
// the value gives the prime, perfect and square flags, a second pass strips
// prime factors for the sphenic flag. The result waits in an output
// register, and the next word is accepted while it waits.
`timescale 1ns / 1ps
`default_nettype none

`include "number_property_classifier_assert.svh"

module number_property_classifier #(
	parameter int VALUE_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [VALUE_BITS-1:0] value,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       is_prime,
	output logic                       is_perfect,
	output logic                       is_square,
	output logic                       is_sphenic
);

	import npc_pkg::*;

	localparam int DW  = (VALUE_BITS + 1) / 2 + 1;
	localparam int SQW = 2 * DW;
	localparam int CW  = $clog2(VALUE_BITS);
	localparam logic [CW-1:0] CNT_LAST = CW'(VALUE_BITS - 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_A_CHK,
		ST_A_DIV,
		ST_A_ACC,
		ST_B_CHK,
		ST_B_DIV1,
		ST_B_EV1,
		ST_B_DIV2,
		ST_B_EV2,
		ST_FIN
	} state_t;

	state_t                 state_q;
	logic                   out_valid_q;
	npc_flags_t             res_q;

	logic [VALUE_BITS-1:0]  v_q;
	logic [VALUE_BITS-1:0]  n_q;
	logic [DW-1:0]          d_q;
	logic [DW-1:0]          rem_q;
	logic [VALUE_BITS-1:0]  quo_q;
	logic [CW-1:0]          cnt_q;
	logic [VALUE_BITS:0]    sum_q;
	logic                   over_q;
	logic                   found_q;
	logic                   sq_q;
	logic [1:0]             pcnt_q;
	logic                   rep_q;

	logic                   accept;
	logic [SQW-1:0]         dsq;
	logic [SQW-1:0]         bound;
	logic                   in_range;
	logic [DW:0]            part;
	logic [DW:0]            d_ext;
	logic                   ge;
	logic [DW:0]            part_sub;
	logic [DW-1:0]          rem_next;
	logic [VALUE_BITS:0]    sum_add;
	logic [VALUE_BITS:0]    cof_add;
	logic [2:0]             pc_total;
	logic                   big_enough;
	logic                   done_div;
	logic                   div_busy;
	logic                   res_other;
	npc_flags_t             flags;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);

	// shared squarer for the trial bound
	assign dsq      = d_q * d_q;
	assign bound    = (state_q == ST_B_CHK) ? SQW'(n_q) : SQW'(v_q);
	assign in_range = (dsq <= bound);

	// one restoring divider step
	assign part     = {rem_q, quo_q[VALUE_BITS-1]};
	assign d_ext    = {1'b0, d_q};
	assign ge       = (part >= d_ext);
	assign part_sub = part - d_ext;
	assign rem_next = ge ? part_sub[DW-1:0] : part[DW-1:0];
	assign done_div = (cnt_q == CNT_LAST);
	assign div_busy = (state_q inside {ST_A_DIV, ST_B_DIV1, ST_B_DIV2});

	assign cof_add  = (quo_q != VALUE_BITS'(d_q)) ? {1'b0, quo_q} : '0;
	assign sum_add  = sum_q + (VALUE_BITS + 1)'(d_q) + cof_add;

	assign big_enough = (v_q > VALUE_BITS'(1));
	assign pc_total   = {1'b0, pcnt_q} + {2'b00, (n_q > VALUE_BITS'(1))};

	always_comb begin
		flags.prime   = big_enough && !found_q;
		flags.perfect = big_enough && !over_q && (sum_q == {1'b0, v_q});
		flags.square  = sq_q;
		flags.sphenic = big_enough && !rep_q && (pc_total == 3'(SPHENIC_FACTORS));
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (out_valid_q && !out_stall && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_A_CHK;
					end
				end
				ST_A_CHK: begin
					state_q <= in_range ? ST_A_DIV : ST_B_CHK;
				end
				ST_A_DIV: begin
					if (done_div) begin
						state_q <= ST_A_ACC;
					end
				end
				ST_A_ACC: begin
					state_q <= ST_A_CHK;
				end
				ST_B_CHK: begin
					state_q <= in_range ? ST_B_DIV1 : ST_FIN;
				end
				ST_B_DIV1: begin
					if (done_div) begin
						state_q <= ST_B_EV1;
					end
				end
				ST_B_EV1: begin
					state_q <= (rem_q == '0) ? ST_B_DIV2 : ST_B_CHK;
				end
				ST_B_DIV2: begin
					if (done_div) begin
						state_q <= ST_B_EV2;
					end
				end
				ST_B_EV2: begin
					if (rem_q == '0 || pcnt_q == 2'(SPHENIC_FACTORS)) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_B_CHK;
					end
				end
				ST_FIN: begin
					if (!out_valid_q || !out_stall) begin
						res_q       <= flags;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					v_q     <= value;
					n_q     <= value;
					d_q     <= DW'(2);
					sum_q   <= (VALUE_BITS + 1)'(1);
					over_q  <= 1'b0;
					found_q <= 1'b0;
					sq_q    <= (value == VALUE_BITS'(1));
					pcnt_q  <= '0;
					rep_q   <= 1'b0;
				end
			end
			ST_A_CHK: begin
				if (dsq == SQW'(v_q)) begin
					sq_q <= 1'b1;
				end
				if (in_range) begin
					rem_q <= '0;
					quo_q <= v_q;
					cnt_q <= '0;
				end else begin
					d_q <= DW'(2);
				end
			end
			ST_A_DIV, ST_B_DIV1, ST_B_DIV2: begin
				rem_q <= rem_next;
				quo_q <= {quo_q[VALUE_BITS-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
			end
			ST_A_ACC: begin
				if (rem_q == '0) begin
					found_q <= 1'b1;
					if (!over_q) begin
						sum_q <= sum_add;
						if (sum_add > {1'b0, v_q}) begin
							over_q <= 1'b1;
						end
					end
				end
				d_q <= d_q + 1'b1;
			end
			ST_B_CHK: begin
				rem_q <= '0;
				quo_q <= n_q;
				cnt_q <= '0;
			end
			ST_B_EV1: begin
				if (rem_q == '0) begin
					n_q   <= quo_q;
					rem_q <= '0;
					cnt_q <= '0;
				end else begin
					d_q <= d_q + 1'b1;
				end
			end
			ST_B_EV2: begin
				if (rem_q == '0 || pcnt_q == 2'(SPHENIC_FACTORS)) begin
					rep_q <= 1'b1;
				end else begin
					pcnt_q <= pcnt_q + 1'b1;
				end
				d_q <= d_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign is_prime   = res_q.prime;
	assign is_perfect = res_q.perfect;
	assign is_square  = res_q.square;
	assign is_sphenic = res_q.sphenic;

	assign res_other  = res_q.perfect || res_q.square || res_q.sphenic;

	`NPC_ASSERT_NXT(a_busy_after_accept, accept, in_stall)
	`NPC_ASSERT_IMP(a_rem_below_divisor, div_busy, rem_q < d_q)
	`NPC_ASSERT_IMP(a_prime_exclusive, out_valid_q, !(res_q.prime && res_other))
	`NPC_ASSERT_IMP(a_rise_from_fin, $rose(out_valid_q), $past(state_q == ST_FIN))

endmodule

`default_nettype wire
